>>> design/lprt_pkg.sv
// Package for the longest-prefix route table.
// Table sizing constants and the controller/datapath command and status structs.
// No dependencies.
package lprt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic load;     // capture the item fields, clear scan state
    logic write;    // append the captured route if room
    logic read_en;  // read entry at scan index, advance index
  } lprt_cmd_t;

  typedef struct packed {
    logic full;       // entry count equals table depth
    logic empty;      // no stored routes
    logic last_read;  // scan index is on the last stored route
  } lprt_stat_t;

endpackage

>>> design/lprt_ctrl.sv
// Controller state machine for the longest-prefix route table.
// Depends on lprt_pkg for the command and status structs.
module lprt_ctrl
  import lprt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       command,
  input  lprt_stat_t stat,
  output lprt_cmd_t  cmd,
  output logic       busy,
  output logic       done
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (command == CMD_INSERT) begin
            state_next = ST_INSERT;
          end else if (stat.empty) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_INSERT: begin
        cmd.write  = 1'b1;
        state_next = ST_FINISH;
      end
      ST_SCAN: begin
        cmd.read_en = 1'b1;
        if (stat.last_read) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_FINISH);

endmodule

>>> design/lprt_datapath.sv
// Datapath for the longest-prefix route table: route memory, scan index,
// match compare and best-route registers. Depends on lprt_pkg.
module lprt_datapath
  import lprt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  lprt_cmd_t   cmd,
  input  logic [31:0] dest_addr,
  input  logic [31:0] gateway_addr,
  input  logic [31:0] prefix_mask,
  input  logic [31:0] dest_clear_mask,
  output lprt_stat_t  stat,
  output logic [31:0] next_hop,
  output logic        status
);

  logic [31:0] mem_dest [TABLE_DEPTH];
  logic [31:0] mem_gw   [TABLE_DEPTH];
  logic [31:0] mem_mask [TABLE_DEPTH];

  logic [CNT_W-1:0] entry_count;
  logic [IDX_W-1:0] scan_idx;

  logic [31:0] key;
  logic [31:0] ins_dest;
  logic [31:0] ins_gw;
  logic [31:0] ins_mask;

  logic [31:0] rd_dest;
  logic [31:0] rd_gw;
  logic [31:0] rd_mask;
  logic        rd_valid;

  logic        found;
  logic [31:0] best_mask;
  logic [31:0] best_gw;
  logic        drop;

  logic        hit;
  logic        better;

  assign stat.full      = (entry_count == CNT_W'(TABLE_DEPTH));
  assign stat.empty     = (entry_count == '0);
  assign stat.last_read = ((CNT_W'(scan_idx) + CNT_W'(1)) == entry_count);

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.write && !stat.full) begin
      mem_dest[entry_count[IDX_W-1:0]] <= ins_dest;
      mem_gw[entry_count[IDX_W-1:0]]   <= ins_gw;
      mem_mask[entry_count[IDX_W-1:0]] <= ins_mask;
    end
    if (cmd.read_en) begin
      rd_dest <= mem_dest[scan_idx];
      rd_gw   <= mem_gw[scan_idx];
      rd_mask <= mem_mask[scan_idx];
    end
  end

  assign hit    = (((rd_dest ^ key) & rd_mask) == 32'd0);
  assign better = !found || (rd_mask > best_mask);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key      <= dest_addr;
      ins_dest <= dest_addr & dest_clear_mask;
      ins_gw   <= gateway_addr;
      ins_mask <= prefix_mask;
    end
    if (rd_valid && hit && better) begin
      best_mask <= rd_mask;
      best_gw   <= rd_gw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      scan_idx    <= '0;
      rd_valid    <= 1'b0;
      found       <= 1'b0;
      drop        <= 1'b0;
    end else begin
      rd_valid <= cmd.read_en;
      if (cmd.load) begin
        scan_idx <= '0;
        found    <= 1'b0;
        drop     <= 1'b0;
      end else begin
        if (cmd.read_en) begin
          scan_idx <= scan_idx + IDX_W'(1);
        end
        if (rd_valid && hit) begin
          found <= 1'b1;
        end
      end
      if (cmd.write) begin
        if (stat.full) begin
          drop <= 1'b1;
        end else begin
          entry_count <= entry_count + CNT_W'(1);
        end
      end
    end
  end

  assign next_hop = found ? best_gw : 32'd0;
  assign status   = drop;

endmodule

>>> design/longest_prefix_route_table.sv
// Top level of the IPv4 longest-prefix route table.
// Instantiates lprt_ctrl and lprt_datapath; depends on lprt_pkg.

// An item is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with done high, and the receiver cannot stall
// it, so capture next_hop and status on that cycle. An insert passes through
// the insert state before the done cycle. A lookup walks the stored
// routes through the table memory's single read port, one entry per cycle,
// then a drain state, before done; on an empty table it goes straight to done.
// busy drops the cycle after done.
// The table starts empty after reset; no clearing pass is needed.
module longest_prefix_route_table
  import lprt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [31:0] dest_addr,
  input  logic [31:0] gateway_addr,
  input  logic [31:0] prefix_mask,
  input  logic [31:0] dest_clear_mask,
  output logic        done,
  output logic [31:0] next_hop,
  output logic        status
);

  lprt_cmd_t  cmd;
  lprt_stat_t stat;

  // sequencing: idle, insert, scan, drain, finish
  lprt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done)
  );

  // route storage and best-match tracking
  lprt_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .dest_addr       (dest_addr),
    .gateway_addr    (gateway_addr),
    .prefix_mask     (prefix_mask),
    .dest_clear_mask (dest_clear_mask),
    .stat            (stat),
    .next_hop        (next_hop),
    .status          (status)
  );

  // a result only appears while an item is in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  // an accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // the block frees up right after delivering its result
  a_done_free: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy held after done");

  // a dropped insert never carries a next hop
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (next_hop == 32'd0))
    else $error("dropped insert with nonzero next hop");

endmodule

>>> tb/sv/lprt_route_checker.sv
`timescale 1ns / 1ps
// Checker for the longest-prefix route table. It keeps its own copy of the route
// store, predicts next_hop and status for each accepted item, and compares each done strobe.
// Depends on lprt_pkg.
module lprt_route_checker
  import lprt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        command,
  input  logic [31:0] dest_addr,
  input  logic [31:0] gateway_addr,
  input  logic [31:0] prefix_mask,
  input  logic [31:0] dest_clear_mask,
  input  logic        done,
  input  logic [31:0] next_hop,
  input  logic        status,
  output int          mismatches,
  output int          outstanding,
  output int          checked,
  output int          hits,
  output int          drops
);

  typedef struct packed {
    logic [31:0] hop;
    logic        dropped;
  } hop_result_t;

  logic [31:0] route_dest [TABLE_DEPTH];
  logic [31:0] route_gw   [TABLE_DEPTH];
  logic [31:0] route_mask [TABLE_DEPTH];
  int          route_count;
  hop_result_t expected_hops[$];
  hop_result_t oldest;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH at %0t ns: %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  // Winner is the matching route with the largest mask; ties keep the earlier route.
  function automatic hop_result_t best_next_hop(logic [31:0] addr, output logic found);
    hop_result_t res;
    logic [31:0] best_mask;
    res = '0;
    best_mask = '0;
    found = 1'b0;
    for (int i = 0; i < route_count; i++) begin
      if ((route_dest[i] & route_mask[i]) == (addr & route_mask[i])) begin
        if (!found || route_mask[i] > best_mask) begin
          found = 1'b1;
          best_mask = route_mask[i];
          res.hop = route_gw[i];
        end
      end
    end
    return res;
  endfunction

  task automatic predict_item();
    hop_result_t res;
    logic found;
    res = '0;
    if (command == CMD_INSERT) begin
      if (route_count >= TABLE_DEPTH) begin
        res.dropped = 1'b1;
        drops++;
      end else begin
        route_dest[route_count] = dest_addr & dest_clear_mask;
        route_gw[route_count] = gateway_addr;
        route_mask[route_count] = prefix_mask;
        route_count++;
      end
    end else begin
      res = best_next_hop(dest_addr, found);
      if (found) hits++;
    end
    expected_hops.insert(expected_hops.size(), res);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      route_count <= 0;
      expected_hops.delete();
      mismatches <= 0;
      outstanding <= 0;
      checked <= 0;
      hits <= 0;
      drops <= 0;
    end else begin
      if (done) begin
        if (expected_hops.size() == 0) begin
          report_mismatch("result with no item pending", next_hop, 32'h0);
        end else begin
          oldest = expected_hops.pop_front();
          if (next_hop !== oldest.hop) report_mismatch("next_hop", next_hop, oldest.hop);
          if (status !== oldest.dropped)
            report_mismatch("status", {31'h0, status}, {31'h0, oldest.dropped});
          checked++;
        end
      end
      if (start && !busy) predict_item();
      outstanding <= expected_hops.size();
    end
  end

endmodule

>>> tb/sv/longest_prefix_route_table_tb.sv
`timescale 1ns / 1ps
// Top of the route table testbench: clock, reset, directed and random items.
// Depends on lprt_pkg, longest_prefix_route_table and lprt_route_checker.
module longest_prefix_route_table_tb;
  import lprt_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RANDOM_ITEMS = 750;
  localparam int CALM_TAIL    = 100;  // last items go back to back
  localparam int SETTLE       = 30;   // longer than a full-table lookup

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        command;
  logic [31:0] dest_addr;
  logic [31:0] gateway_addr;
  logic [31:0] prefix_mask;
  logic [31:0] dest_clear_mask;
  logic        done;
  logic [31:0] next_hop;
  logic        status;

  int mismatches;
  int outstanding;
  int checked;
  int hits;
  int drops;

  // Stored routes as the table should hold them. Used to aim lookups at real prefixes,
  // to build nested and tied routes and to set the insert rate, not to predict results.
  logic [31:0] known_dest[$];
  logic [31:0] known_mask[$];
  int          items_sent;

  longest_prefix_route_table uut (.*);

  lprt_route_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop. A correct run is well under a tenth of this.
  initial begin
    #(5_000_000);
    $display("Timeout: the block stopped answering");
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [31:0] prefix_of(int len);
    return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
  endfunction

  // Called just after a falling edge. Start stays high once the item is taken.
  // The caller lowers it with rest_for() or drives the next item.
  // busy only moves on rising edges, so it is safe to check here.
  task automatic send_item(logic cmd, logic [31:0] da, logic [31:0] gw,
                           logic [31:0] pm, logic [31:0] cm);
    command = cmd;
    dest_addr = da;
    gateway_addr = gw;
    prefix_mask = pm;
    dest_clear_mask = cm;
    start = 1'b1;
    while (busy) @(negedge clk);
    @(negedge clk);
    items_sent++;
    if (cmd == CMD_INSERT && known_dest.size() < TABLE_DEPTH) begin
      known_dest.insert(known_dest.size(), da & cm);
      known_mask.insert(known_mask.size(), pm);
    end
  endtask

  // Sender gap. The fields carry junk, which the block must ignore while start is low.
  task automatic rest_for(int n);
    start = 1'b0;
    repeat (n) begin
      command = 1'($urandom_range(0, 1));
      dest_addr = $urandom;
      gateway_addr = $urandom;
      prefix_mask = $urandom;
      dest_clear_mask = $urandom;
      @(negedge clk);
    end
  endtask

  initial begin
    int          k;
    int          len;
    int          mode;
    int          b;
    int          drain;
    logic        cmd;
    logic        gaps_on;
    logic [31:0] da;
    logic [31:0] gw;
    logic [31:0] pm;
    logic [31:0] cm;

    rst = 1'b1;
    start = 1'b0;
    command = CMD_INSERT;
    dest_addr = '0;
    gateway_addr = '0;
    prefix_mask = '0;
    dest_clear_mask = '0;
    items_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part.
    // Lookups on an empty table must miss.
    send_item(CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
    // 10.0.0.0/8. Then one address inside it and one outside.
    send_item(CMD_INSERT, 32'h0A00_0000, 32'h0A00_0001, 32'hFF00_0000, 32'hFFFF_FFFF);
    send_item(CMD_LOOKUP, 32'h0A05_0505, 32'h0, 32'h0, 32'h0);
    send_item(CMD_LOOKUP, 32'h0B00_0000, 32'h0, 32'h0, 32'h0);
    // 10.1.0.0/16. The clearing mask strips the host bits of 10.1.77.88.
    send_item(CMD_INSERT, 32'h0A01_4D58, 32'h0A01_00AA, 32'hFFFF_0000, 32'hFFFF_0000);
    // Same /16 again with another gateway. The earlier route must keep winning.
    send_item(CMD_INSERT, 32'h0A01_0000, 32'h0A01_00BB, 32'hFFFF_0000, 32'hFFFF_FFFF);
    // 10.1.2.0/24 with gateway zero. A hit here looks like a miss.
    send_item(CMD_INSERT, 32'h0A01_0263, 32'h0000_0000, 32'hFFFF_FF00, 32'hFFFF_FF00);
    // Default route. Mask zero, destination fully cleared.
    send_item(CMD_INSERT, 32'hFFFF_FFFF, 32'hC0A8_0001, 32'h0000_0000, 32'h0000_0000);
    // Non-contiguous mask.
    send_item(CMD_INSERT, 32'hAB00_CD00, 32'h1234_5678, 32'hFF00_FF00, 32'hFFFF_FFFF);
    // All-ones host route.
    send_item(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_LOOKUP, 32'h0A01_0203, 32'h0, 32'h0, 32'h0);  // /24, gateway zero
    send_item(CMD_LOOKUP, 32'h0A01_0909, 32'h0, 32'h0, 32'h0);  // first /16
    send_item(CMD_LOOKUP, 32'h0A09_0909, 32'h0, 32'h0, 32'h0);  // /8
    send_item(CMD_LOOKUP, 32'h0102_0304, 32'h0, 32'h0, 32'h0);  // default
    send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);  // host route
    send_item(CMD_LOOKUP, 32'hFFFF_FFFE, 32'h0, 32'h0, 32'h0);  // just misses host
    send_item(CMD_LOOKUP, 32'hAB12_CD34, 32'h0, 32'h0, 32'h0);  // non-contiguous
    send_item(CMD_LOOKUP, 32'h0000_0000, 32'h0, 32'h0, 32'h0);  // default again

    // Random part. Inserts fill the rest of the table, half of them with routes that
    // nest inside or tie with stored ones. After that, inserts only test the
    // full-table drop. Most lookups are aimed at stored prefixes, so the ranking
    // sees several matches at once.
    gaps_on = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      if (known_dest.size() < TABLE_DEPTH) cmd = ($urandom_range(0, 99) < 35) ? CMD_INSERT
                                                                           : CMD_LOOKUP;
      else cmd = ($urandom_range(0, 99) < 12) ? CMD_INSERT : CMD_LOOKUP;
      da = $urandom;
      gw = ($urandom_range(0, 9) == 0) ? 32'h0 : $urandom;
      pm = $urandom;
      cm = $urandom;
      mode = $urandom_range(0, 3);
      if (cmd == CMD_INSERT) begin
        if (mode == 1) begin
          // Plain prefix.
          pm = prefix_of($urandom_range(0, 32));
          if ($urandom_range(0, 1) == 1) cm = 32'hFFFF_FFFF;
          else cm = prefix_of($urandom_range(0, 32));
        end else if (mode >= 2 && known_dest.size() > 0) begin
          k = $urandom_range(0, known_dest.size() - 1);
          if (mode == 2) begin
            // Longer prefix inside a stored route.
            len = $urandom_range(0, 32);
            pm = known_mask[k] | prefix_of(len);
            da = (known_dest[k] & known_mask[k]) | (da & ~known_mask[k]);
          end else begin
            // Same mask and destination as a stored route. The earlier one must win.
            pm = known_mask[k];
            da = known_dest[k];
          end
          cm = 32'hFFFF_FFFF;
        end
      end else if (mode != 0 && known_dest.size() > 0) begin
        k = $urandom_range(0, known_dest.size() - 1);
        da = (known_dest[k] & known_mask[k]) | (da & ~known_mask[k]);
        // Sometimes break the match by one bit inside the mask.
        if (known_mask[k] != 0 && $urandom_range(0, 9) == 0) begin
          do b = $urandom_range(0, 31); while (!known_mask[k][b]);
          da[b] = ~da[b];
        end
      end
      send_item(cmd, da, gw, pm, cm);
      if (gaps_on && i < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 99) < 30)
        rest_for($urandom_range(1, 11));
    end
    start = 1'b0;

    // Drain. Every accepted item owes exactly one result.
    drain = 0;
    while (outstanding != 0 && drain < 1000) begin
      @(negedge clk);
      drain++;
    end
    repeat (SETTLE) @(negedge clk);
    if (outstanding != 0) $display("%0d results never arrived", outstanding);

    $display("Sent %0d items and checked %0d results; %0d lookups found a route,",
             items_sent, checked, hits);
    $display("%0d inserts were dropped on a full table of %0d routes", drops, TABLE_DEPTH);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
design/lprt_pkg.sv
design/lprt_ctrl.sv
design/lprt_datapath.sv
design/longest_prefix_route_table.sv
tb/sv/lprt_route_checker.sv
tb/sv/longest_prefix_route_table_tb.sv
